>>> src/bblc_pkg.sv
`default_nettype none
package bblc_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UNLOAD = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_IMAGE  = 2'd0;
  localparam logic [1:0] KIND_FONT   = 2'd1;
  localparam logic [1:0] KIND_CONFIG = 2'd2;
  localparam logic [1:0] KIND_AUDIO  = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EVICTED  = 3'd4;
  localparam logic [2:0] ST_UNLOADED = 3'd5;
  localparam logic [2:0] ST_ABSENT   = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  localparam logic [39:0] BUDGET_RESET = 40'd104857600;

  // key, kind, bytes, stamp
  localparam int ENTRY_W = 32 + 2 + 32 + 64;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  kind;
    logic [31:0] bytes;
    logic [63:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  kind;
    logic [13:0] width;
    logic [13:0] height;
    logic [15:0] glyph;
    logic [23:0] msec;
  } size_req_t;
endpackage
`default_nettype wire

>>> src/byte_budget_lru_cache_unit.sv
// A hit, mismatch, unload or absent result follows one full scan of the entries, a
// load that misses also waits for the sizer, a clear needs no scan; each eviction
// adds a further scan; every full scan reads the entry memory one slot a cycle.
// Requests are handled one at a time; the next request is taken once the last
// result has left the output register.
// Reset: synchronous; clears valid bits, counters and stamp clock, restores the
// budget to its default. The entry memory keeps its contents; a scan reads every
// slot, but only valid slots take part.
`default_nettype none
module byte_budget_lru_cache_unit
  import bblc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], item_key[33:2], item_kind[35:34], pixel_width[49:36],
  // pixel_height[63:50], glyph_size[79:64], duration_msec[103:80]
  input  wire logic [103:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], result_key[34:3], entry_bytes[66:35], used_bytes[106:67],
  // used_slots[111:107]
  output logic [111:0]     m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [39:0] cfg_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_SIZE  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_LRU   = 3'd4;
  localparam logic [2:0] S_EVICT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state;
  logic [39:0] budget;
  logic [SLOTS-1:0] valid;
  logic [63:0] clock_cnt;
  logic [39:0] total;
  logic [CNT_W-1:0] used;

  // held request
  logic [1:0]  op;
  logic [31:0] key;
  logic [1:0]  kind;
  logic [31:0] size;
  logic        missed;

  // scan
  logic [CNT_W-1:0] scan;
  logic [SLOT_W-1:0] rd_idx;
  logic        rd_live;
  logic        found;
  logic [SLOT_W-1:0] best;
  logic [63:0] best_stamp;
  entry_t      best_ent;

  // memory
  logic        we;
  logic [SLOT_W-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  // output register
  logic        out_valid;
  logic [2:0]  o_status;
  logic [31:0] o_key, o_bytes;
  logic        o_last;

  size_req_t   sreq;
  logic        sdone;
  logic [31:0] sbytes;

  bblc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bblc_sizer u_sizer (.clk, .rst, .req(sreq), .done(sdone), .bytes(sbytes));

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast = o_last;
  assign m_axis_tdata = {o_last ? used : used, total, o_bytes, o_key, o_status};
  assign raddr = scan[SLOT_W-1:0];

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = SLOT_W'(i);
    end
  end

  logic [40:0] need;
  assign need = {1'b0, total} + {9'd0, size};

  always_comb begin
    sreq.start  = accept && (s_axis_tdata[1:0] == OP_LOAD);
    sreq.kind   = s_axis_tdata[35:34];
    sreq.width  = s_axis_tdata[49:36];
    sreq.height = s_axis_tdata[63:50];
    sreq.glyph  = s_axis_tdata[79:64];
    sreq.msec   = s_axis_tdata[103:80];
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      budget <= BUDGET_RESET;
      valid <= '0;
      clock_cnt <= '0;
      total <= '0;
      used <= '0;
      out_valid <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      if (cfg_valid) budget <= cfg_data;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      rd_live <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= s_axis_tdata[1:0];
            key <= s_axis_tdata[33:2];
            kind <= s_axis_tdata[35:34];
            scan <= '0;
            found <= 1'b0;
            missed <= 1'b0;
            priority case (s_axis_tdata[1:0])
              OP_LOAD, OP_UNLOAD: state <= S_FIND;
              OP_CLEAR: begin
                valid <= '0;
                total <= '0;
                used <= '0;
                o_status <= ST_CLEARED;
                o_key <= s_axis_tdata[33:2];
                o_bytes <= '0;
                o_last <= 1'b1;
                out_valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        // issue reads for scan 0..SLOTS-1, compare in the next cycle
        S_FIND: begin
          if (scan < CNT_W'(SLOTS)) begin
            rd_live <= 1'b1;
            rd_idx <= raddr;
            scan <= scan + 1'b1;
          end
          if (rd_live && valid[rd_idx] && rdata.key == key && !found) begin
            found <= 1'b1;
            best <= rd_idx;
            best_ent <= rdata;
          end
          if (!rd_live && scan == CNT_W'(SLOTS)) begin
            state <= S_DEC;
          end
        end
        S_SIZE: begin
          if (sdone) size <= sbytes;
          if (sdone || missed) begin
            missed <= 1'b1;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (!out_valid) begin
            priority if (op == OP_UNLOAD) begin
              o_key <= key;
              o_last <= 1'b1;
              out_valid <= 1'b1;
              if (found) begin
                valid[best] <= 1'b0;
                total <= total - {8'd0, best_ent.bytes};
                used <= used - 1'b1;
                o_status <= ST_UNLOADED;
                o_bytes <= best_ent.bytes;
              end else begin
                o_status <= ST_ABSENT;
                o_bytes <= '0;
              end
              state <= S_OUT;
            end else if (found) begin
              we <= 1'b1;
              waddr <= best;
              wdata <= '{key: best_ent.key, kind: best_ent.kind,
                         bytes: best_ent.bytes, stamp: clock_cnt};
              clock_cnt <= clock_cnt + 1'b1;
              o_status <= (best_ent.kind == kind) ? ST_HIT : ST_MISMATCH;
              o_key <= key;
              o_bytes <= best_ent.bytes;
              o_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else if (!missed) begin
              state <= S_SIZE;
            end else if ((need > {1'b0, budget} && used != '0) ||
                         (need <= {1'b0, budget} && used == CNT_W'(SLOTS))) begin
              scan <= '0;
              found <= 1'b0;
              state <= S_LRU;
            end else if (need > {1'b0, budget}) begin
              o_status <= ST_FULL;
              o_key <= key;
              o_bytes <= size;
              o_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              we <= 1'b1;
              waddr <= free_idx;
              wdata <= '{key: key, kind: kind, bytes: size, stamp: clock_cnt};
              clock_cnt <= clock_cnt + 1'b1;
              valid[free_idx] <= 1'b1;
              total <= need[39:0];
              used <= used + 1'b1;
              o_status <= ST_LOADED;
              o_key <= key;
              o_bytes <= size;
              o_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        // minimum stamp scan, strict less keeps the lowest index on ties
        S_LRU: begin
          if (scan < CNT_W'(SLOTS)) begin
            rd_live <= 1'b1;
            rd_idx <= raddr;
            scan <= scan + 1'b1;
          end
          if (rd_live && valid[rd_idx] && (!found || rdata.stamp < best_stamp)) begin
            found <= 1'b1;
            best <= rd_idx;
            best_stamp <= rdata.stamp;
            best_ent <= rdata;
          end
          if (!rd_live && scan == CNT_W'(SLOTS)) begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (!out_valid) begin
            valid[best] <= 1'b0;
            total <= total - {8'd0, best_ent.bytes};
            used <= used - 1'b1;
            o_status <= ST_EVICTED;
            o_key <= best_ent.key;
            o_bytes <= best_ent.bytes;
            o_last <= 1'b0;
            out_valid <= 1'b1;
            found <= 1'b0;
            state <= S_DEC;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used))
    else $error("slot count out of step with valid bits");
  assert property (@(posedge clk) disable iff (rst)
    accept |-> !out_valid)
    else $error("request taken with a result pending");
endmodule
`default_nettype wire

>>> src/bblc_ram.sv
`default_nettype none
module bblc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/bblc_sizer.sv
`default_nettype none
module bblc_sizer
  import bblc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire size_req_t req,
  output logic           done,
  output logic [31:0]    bytes
);
  // Stage 1 registers the partial products, stage 2 adds them, stage 3 scales.
  // done stays high from the end of the last stage until the next start.
  logic [1:0]  step;
  logic [1:0]  kind;
  logic [40:0] prod;
  logic [20:0] tenth;
  logic [40:0] quot;
  logic [47:0] tenth_prod;

  // floor(msec / 10) via reciprocal multiply, exact for msec < 2^26
  assign tenth_prod = req.msec * 24'd13421773;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (req.start) begin
      step <= 2'd1;
    end else if (step != 2'd0 && step != 2'd3) begin
      step <= step + 2'd1;
    end
    if (req.start) begin
      kind <= req.kind;
      tenth <= tenth_prod[47:27];
      unique case (req.kind)
        KIND_IMAGE: prod <= {13'd0, 28'(req.width * req.height)};
        KIND_FONT:  prod <= {25'd0, req.glyph};
        KIND_AUDIO: prod <= 41'(req.msec * 6'd44);
        default:    prod <= 41'd0;
      endcase
    end
    if (step == 2'd1) begin
      // floor(msec * 441 / 10) = 44 * msec + floor(msec / 10)
      quot <= prod + {20'd0, tenth};
    end
    if (step == 2'd2) begin
      unique case (kind)
        KIND_IMAGE: bytes <= {prod[29:0], 2'b00};
        KIND_FONT:  bytes <= {prod[21:0], 10'd0};
        KIND_AUDIO: bytes <= {quot[29:0], 2'b00};
        default:    bytes <= 32'd21;
      endcase
    end
  end

  assign done = (step == 2'd3);
endmodule
`default_nettype wire

>>> dv/bblc_checker.sv
`default_nettype none
module bblc_checker
  import bblc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [111:0] m_axis_tdata,
  input  wire logic         m_axis_tlast,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [39:0]  cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key;
    logic [31:0] bytes;
    logic [39:0] used;
    logic [4:0]  slots;
    logic        last;
  } cache_result_t;

  cache_result_t result_q[$];

  logic        slot_valid [SLOTS];
  logic [31:0] slot_key   [SLOTS];
  logic [1:0]  slot_kind  [SLOTS];
  logic [31:0] slot_bytes [SLOTS];
  logic [63:0] slot_stamp [SLOTS];
  logic [63:0] stamp_clock;
  logic [39:0] used_total;
  logic [39:0] budget;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_valid[i]) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  task automatic post(logic [2:0] status, logic [31:0] key, logic [31:0] bytes);
    cache_result_t r;
    r.status = status;
    r.key    = key;
    r.bytes  = bytes;
    r.used   = used_total;
    r.slots  = 5'(live_slots());
    r.last   = 1'b0;
    result_q.push_back(r);
  endtask

  // Drop the least recently stamped entry; ties go to the lowest slot.
  task automatic drop_lru();
    int v;
    v = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && (v < 0 || slot_stamp[i] < slot_stamp[v])) v = i;
    if (v >= 0) begin
      slot_valid[v] = 1'b0;
      used_total = used_total - 40'(slot_bytes[v]);
      post(ST_EVICTED, slot_key[v], slot_bytes[v]);
    end
  endtask

  task automatic apply_request(logic [103:0] d);
    logic [1:0]  op;
    logic [31:0] key;
    logic [1:0]  kind;
    logic [63:0] sz;
    int s, first;
    op    = d[1:0];
    key   = d[33:2];
    kind  = d[35:34];
    first = result_q.size();
    if (op == OP_LOAD) begin
      s = find_slot(key);
      if (s >= 0) begin
        slot_stamp[s] = stamp_clock;
        stamp_clock++;
        post((slot_kind[s] == kind) ? ST_HIT : ST_MISMATCH, key, slot_bytes[s]);
      end else begin
        case (kind)
          KIND_IMAGE:  sz = 64'(d[49:36]) * 64'(d[63:50]) * 4;
          KIND_FONT:   sz = 64'(d[79:64]) * 1024;
          KIND_CONFIG: sz = 64'd21;
          default:     sz = (64'(d[103:80]) * 44100 / 1000) * 4;
        endcase
        while (64'(used_total) + sz > 64'(budget) && live_slots() > 0) drop_lru();
        if (64'(used_total) + sz > 64'(budget)) begin
          post(ST_FULL, key, sz[31:0]);
        end else begin
          if (live_slots() >= SLOTS) drop_lru();
          s = -1;
          for (int i = 0; i < SLOTS; i++)
            if (s < 0 && !slot_valid[i]) s = i;
          slot_valid[s] = 1'b1;
          slot_key[s]   = key;
          slot_kind[s]  = kind;
          slot_bytes[s] = sz[31:0];
          slot_stamp[s] = stamp_clock;
          stamp_clock++;
          used_total = used_total + sz[39:0];
          post(ST_LOADED, key, sz[31:0]);
        end
      end
    end else if (op == OP_UNLOAD) begin
      s = find_slot(key);
      if (s >= 0) begin
        slot_valid[s] = 1'b0;
        used_total = used_total - 40'(slot_bytes[s]);
        post(ST_UNLOADED, key, slot_bytes[s]);
      end else begin
        post(ST_ABSENT, key, 32'd0);
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      used_total = '0;
      post(ST_CLEARED, key, 32'd0);
    end
    if (result_q.size() > first) result_q[result_q.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      stamp_clock = '0;
      used_total  = '0;
      budget      = BUDGET_RESET;
      result_q.delete();
    end else begin
      // Check the outgoing result first: it belongs to an earlier request.
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(m_axis_tdata[2:0]), 64'd0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[2:0] != want.status)
            report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
          if (m_axis_tdata[34:3] != want.key)
            report_mismatch("result_key", 64'(m_axis_tdata[34:3]), 64'(want.key));
          if (m_axis_tdata[66:35] != want.bytes)
            report_mismatch("entry_bytes", 64'(m_axis_tdata[66:35]), 64'(want.bytes));
          if (m_axis_tdata[106:67] != want.used)
            report_mismatch("used_bytes", 64'(m_axis_tdata[106:67]), 64'(want.used));
          if (m_axis_tdata[111:107] != want.slots)
            report_mismatch("used_slots", 64'(m_axis_tdata[111:107]), 64'(want.slots));
          if (m_axis_tlast != want.last)
            report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) budget = cfg_data;
      if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tdata);
    end
    pending <= result_q.size();
  end

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb
  import bblc_pkg::*;
();

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // opcode, item_key, item_kind, pixel_width, pixel_height, glyph_size, duration_msec
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // status, result_key, entry_bytes, used_bytes, used_slots
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [39:0]  cfg_data;

  int errors;
  int pending;
  int idle_pct;   // chance per cycle that the sender holds back
  int stall_pct;  // chance per cycle that the receiver refuses a result
  bit hold_go;    // ask the receiver for one long hold-off
  int quiet_cycles;

  byte_budget_lru_cache_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bblc_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any accepted request, result or register write restarts the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request and hold it until taken; then idle cycle by cycle.
  task automatic send_request(logic [1:0] op, logic [31:0] key, logic [1:0] kind,
                              logic [13:0] w, logic [13:0] h, logic [15:0] g,
                              logic [23:0] ms);
    s_axis_tdata  <= {ms, g, h, w, kind, key, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain every expected result, let the block settle, then write the budget.
  task automatic write_budget(logic [39:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly loads over a small key pool so hits, evictions and refills mix.
  task automatic random_request();
    int r;
    logic [1:0]  op;
    logic [31:0] key;
    r = $urandom_range(99);
    if (r < 72) op = OP_LOAD;
    else if (r < 92) op = OP_UNLOAD;
    else if (r < 96) op = OP_CLEAR;
    else op = 2'd3;
    key = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 20)) : 32'($urandom);
    send_request(op, key, 2'($urandom_range(3)),
                 14'(($urandom_range(99) < 75) ? $urandom_range(127) : $urandom_range(16383)),
                 14'(($urandom_range(99) < 75) ? $urandom_range(127) : $urandom_range(16383)),
                 16'(($urandom_range(99) < 75) ? $urandom_range(63) : $urandom_range(65535)),
                 24'(($urandom_range(99) < 75) ? $urandom_range(2000) : $urandom));
  endtask

  initial begin
    logic [39:0] phase_budget [4];
    int          phase_idle   [4];
    int          phase_stall  [4];
    phase_budget = '{40'd104857600, 40'd200000, 40'hFF_FFFF_FFFF, 40'd1000000};
    phase_idle   = '{0, 83, 0, 26};
    phase_stall  = '{0, 0, 83, 26};
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_go       = 1'b0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset budget.
    send_request(OP_LOAD, 32'd1, KIND_IMAGE, 14'h3FFF, 14'h3FFF, 16'd0, 24'd0); // too big
    send_request(OP_LOAD, 32'd2, KIND_CONFIG, 14'd0, 14'd0, 16'd0, 24'd0);
    send_request(OP_LOAD, 32'd2, KIND_CONFIG, 14'd0, 14'd0, 16'd0, 24'd0);       // hit
    send_request(OP_LOAD, 32'd2, KIND_FONT, 14'd0, 14'd0, 16'd0, 24'd0);         // wrong kind
    send_request(OP_LOAD, 32'd3, KIND_FONT, 14'd0, 14'd0, 16'hFFFF, 24'd0);
    send_request(OP_LOAD, 32'd4, KIND_AUDIO, 14'd0, 14'd0, 16'd0, 24'hFFFFFF);  // evict all, full
    send_request(OP_LOAD, 32'd5, KIND_IMAGE, 14'd0, 14'h3FFF, 16'd0, 24'd0);    // zero size
    send_request(OP_LOAD, 32'd6, KIND_AUDIO, 14'd0, 14'd0, 16'd0, 24'd1000);
    send_request(OP_UNLOAD, 32'd6, KIND_IMAGE, 14'd0, 14'd0, 16'd0, 24'd0);
    send_request(OP_UNLOAD, 32'd6, KIND_IMAGE, 14'd0, 14'd0, 16'd0, 24'd0);     // absent
    send_request(2'd3, 32'hFFFF_FFFF, 2'd3, 14'h3FFF, 14'h3FFF, 16'hFFFF, 24'hFFFFFF);
    send_request(OP_LOAD, 32'hFFFF_FFFF, KIND_IMAGE, 14'd100, 14'd100, 16'd0, 24'd0);
    send_request(OP_LOAD, 32'd3, KIND_FONT, 14'd0, 14'd0, 16'hFFFF, 24'd0);
    send_request(OP_LOAD, 32'd7, KIND_FONT, 14'd0, 14'd0, 16'hFFFF, 24'd0);     // evicts LRU
    send_request(OP_CLEAR, 32'hA5A5_A5A5, KIND_IMAGE, 14'd0, 14'd0, 16'd0, 24'd0);
    send_request(OP_UNLOAD, 32'd2, KIND_IMAGE, 14'd0, 14'd0, 16'd0, 24'd0);

    // Zero budget: only zero-sized entries fit.
    write_budget(40'd0);
    send_request(OP_LOAD, 32'd8, KIND_CONFIG, 14'd0, 14'd0, 16'd0, 24'd0);
    send_request(OP_LOAD, 32'd9, KIND_IMAGE, 14'h3FFF, 14'd0, 16'd0, 24'd0);

    // Widest budget: overfill the slots so the table itself forces evictions.
    write_budget(40'hFF_FFFF_FFFF);
    for (int i = 0; i < 18; i++)
      send_request(OP_LOAD, 32'(100 + i), KIND_CONFIG, 14'd0, 14'd0, 16'd0, 24'd0);

    // Random phases, each under its own budget and idling pattern.
    for (int p = 0; p < 4; p++) begin
      write_budget(phase_budget[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < 88; n++) begin
        // Hold off the receiver while requests keep coming in.
        if (p == 0 && n == 20) hold_go = 1'b1;
        random_request();
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
